// File: rtl/core/kllh_pkg.sv
package kllh_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FILTERED = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] CFG_FILTER_EN  = 2'd0;
    localparam logic [1:0] CFG_FILTER_PID = 2'd1;
    localparam logic [1:0] CFG_GROUP_BY   = 2'd2;
    localparam logic [1:0] CFG_UNIT_MS    = 2'd3;

    localparam logic [1:0] GB_PROCESS = 2'd1;
    localparam logic [1:0] GB_THREAD  = 2'd2;

    // Item classes handed from the front to the back.
    localparam logic [1:0] K_IMM   = 2'd0;
    localparam logic [1:0] K_START = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;
    localparam logic [1:0] K_READ  = 2'd3;

    localparam logic [31:0] GLOBAL_ID = 32'hFFFF_FFFF;
    localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;
    localparam logic [63:0] DIV_US    = 64'd1000;
    localparam logic [63:0] DIV_MS    = 64'd1000000;

    typedef struct packed {
        logic        filter_en;
        logic [31:0] filter_pid;
        logic [1:0]  group_by;
        logic        unit_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  imm_status;
        logic [31:0] pid;
        logic [31:0] tid;
        logic [63:0] time_ns;
        logic [2:0]  mode;
        logic [3:0]  reason;
        logic [5:0]  rgroup;
        logic [4:0]  rbin;
    } t_item;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  mode;
        logic [3:0]  reason;
    } t_gkey;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + 32'd1;
    endfunction

endpackage

// File: rtl/core/keyed_latency_log2_histogram_core.sv
// Channel     | Direction | Handshake                      | Payload
// ------------+-----------+--------------------------------+------------------------------
// command     | in        | start & !busy                  | i_op .. i_read_bin
// result      | out       | o_valid, one cycle, no stall   | o_status .. o_bin_count
// config      | in        | i_cfg_valid & o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Commands go into a 2-deep queue; the back end handles one transaction at a
// time. Start-table and group-table lookups are linear scans, a memory read and a
// compare per used entry. An end event then runs the log2 shift, followed by the
// counter update, or by the bin-row init when it opens a new group.
// Reset clears the fill counts and control state; no memory sweep is needed since the
// tables fill in order and a new group's bin row is initialized on allocation.
// busy rises when the queue is full; the result side is never stalled.
module keyed_latency_log2_histogram_core
    import kllh_pkg::*;
#(
    parameter int START_ENTRIES = 64,
    parameter int GROUP_ENTRIES = 64,
    parameter int NUM_BINS      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_process_id,
    input  logic [31:0] i_thread_id,
    input  logic [63:0] i_time_ns,
    input  logic [2:0]  i_mode_code,
    input  logic [3:0]  i_reason_code,
    input  logic [5:0]  i_read_group,
    input  logic [4:0]  i_read_bin,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_group_valid,
    output logic [31:0] o_group_key_id,
    output logic [2:0]  o_group_mode,
    output logic [3:0]  o_group_reason,
    output logic [31:0] o_group_total,
    output logic [31:0] o_bin_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_item q_item;

    // Config writes are always taken; every index of the port maps to a register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FILTER_EN:  r_cfg.filter_en  <= i_cfg_data[0];
                CFG_FILTER_PID: r_cfg.filter_pid <= i_cfg_data;
                CFG_GROUP_BY:   r_cfg.group_by   <= i_cfg_data[1:0];
                CFG_UNIT_MS:    r_cfg.unit_ms    <= i_cfg_data[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Front: filter and classify, then queue.
    kllh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_process_id  (i_process_id),
        .i_thread_id   (i_thread_id),
        .i_time_ns     (i_time_ns),
        .i_mode_code   (i_mode_code),
        .i_reason_code (i_reason_code),
        .i_read_group  (i_read_group),
        .i_read_bin    (i_read_bin),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    // Back: table lookups, binning and counter updates.
    kllh_back #(
        .START_ENTRIES (START_ENTRIES),
        .GROUP_ENTRIES (GROUP_ENTRIES),
        .NUM_BINS      (NUM_BINS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_group_valid  (o_group_valid),
        .o_group_key_id (o_group_key_id),
        .o_group_mode   (o_group_mode),
        .o_group_reason (o_group_reason),
        .o_group_total  (o_group_total),
        .o_bin_count    (o_bin_count)
    );

endmodule

// File: rtl/core/kllh_front.sv
module kllh_front
    import kllh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_process_id,
    input  logic [31:0] i_thread_id,
    input  logic [63:0] i_time_ns,
    input  logic [2:0]  i_mode_code,
    input  logic [3:0]  i_reason_code,
    input  logic [5:0]  i_read_group,
    input  logic [4:0]  i_read_bin,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       push, pop;

    always_comb begin
        cls.pid        = i_process_id;
        cls.tid        = i_thread_id;
        cls.time_ns    = i_time_ns;
        cls.mode       = i_mode_code;
        cls.reason     = i_reason_code;
        cls.rgroup     = i_read_group;
        cls.rbin       = i_read_bin;
        cls.imm_status = ST_DONE;
        cls.kind       = K_IMM;
        if ((i_op == OP_START) || (i_op == OP_END)) begin
            if (i_cfg.filter_en && (i_process_id != i_cfg.filter_pid)) begin
                cls.imm_status = ST_FILTERED;
            end else begin
                cls.kind = (i_op == OP_START) ? K_START : K_END;
            end
        end else if (i_op == OP_READ) begin
            cls.kind = K_READ;
        end
    end

    assign busy      = (r_cnt == 2'd2);
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/core/kllh_back.sv
module kllh_back
    import kllh_pkg::*;
#(
    parameter int START_ENTRIES = 64,
    parameter int GROUP_ENTRIES = 64,
    parameter int NUM_BINS      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_group_valid,
    output logic [31:0] o_group_key_id,
    output logic [2:0]  o_group_mode,
    output logic [3:0]  o_group_reason,
    output logic [31:0] o_group_total,
    output logic [31:0] o_bin_count
);

    localparam int SW  = $clog2(START_ENTRIES);
    localparam int SCW = $clog2(START_ENTRIES + 1);
    localparam int GW  = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
    localparam int GCW = $clog2(GROUP_ENTRIES + 1);
    localparam int BW  = $clog2(NUM_BINS);
    localparam int GDEPTH = 1 << GW;
    localparam int BDEPTH = GDEPTH << BW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_GRD  = 4'd3;
    localparam logic [3:0] S_GCMP = 4'd4;
    localparam logic [3:0] S_LOG  = 4'd5;
    localparam logic [3:0] S_UPD  = 4'd6;
    localparam logic [3:0] S_CLR  = 4'd7;
    localparam logic [3:0] S_RDW  = 4'd8;

    logic [31:0] m_sthr  [START_ENTRIES];
    logic [63:0] m_stime [START_ENTRIES];
    t_gkey       m_gkey  [GDEPTH];
    logic [31:0] m_gevt  [GDEPTH];
    logic [31:0] m_bins  [BDEPTH];

    logic [31:0] rd_thr;
    logic [63:0] rd_time;
    t_gkey       rd_key;
    logic [31:0] rd_evt, rd_bin;

    logic [3:0]     r_st, n_st;
    t_item          r_it, n_it;
    logic [SCW-1:0] r_scnt, n_scnt, r_idx, n_idx;
    logic [GCW-1:0] r_gcnt, n_gcnt, r_gidx, n_gidx;
    logic [63:0]    r_delta, n_delta;
    logic [BW-1:0]  r_bin, n_bin, r_clr, n_clr;
    logic           r_new, n_new;

    logic        r_ov, n_ov;
    logic [1:0]  r_ost, n_ost;
    logic        r_ogv, n_ogv;
    t_gkey       r_okey, n_okey;
    logic [31:0] r_otot, n_otot, r_obin, n_obin;

    logic        s_we;
    logic [SW-1:0] s_waddr;
    logic        s_wthr;
    logic        g_kwe, g_ewe, b_we;
    logic [GW-1:0] g_raddr, g_waddr;
    logic [31:0] g_ewdata, b_wdata;
    logic [GW+BW-1:0] b_raddr, b_waddr;

    t_gkey       cur_key;
    logic [63:0] divisor;
    logic        rb_ok;

    always_comb begin
        unique case (i_cfg.group_by)
            GB_PROCESS: cur_key.id = r_it.pid;
            GB_THREAD:  cur_key.id = r_it.tid;
            default:    cur_key.id = GLOBAL_ID;
        endcase
        cur_key.mode   = r_it.mode;
        cur_key.reason = r_it.reason;
    end

    assign divisor = i_cfg.unit_ms ? DIV_MS : DIV_US;
    assign rb_ok   = (32'(r_it.rbin) < 32'(NUM_BINS));

    // Read addresses: a read op uses the item fields as it is popped.
    always_comb begin
        if (r_st == S_IDLE) begin
            g_raddr = GW'(i_q_item.rgroup);
            b_raddr = {GW'(i_q_item.rgroup), BW'(i_q_item.rbin)};
        end else begin
            g_raddr = r_gidx[GW-1:0];
            b_raddr = {r_gidx[GW-1:0], r_bin};
        end
    end

    always_ff @(posedge i_clk) begin
        rd_thr  <= m_sthr[r_idx[SW-1:0]];
        rd_time <= m_stime[r_idx[SW-1:0]];
        rd_key  <= m_gkey[g_raddr];
        rd_evt  <= m_gevt[g_raddr];
        rd_bin  <= m_bins[b_raddr];
        if (s_we) begin
            m_stime[s_waddr] <= r_it.time_ns;
            if (s_wthr) m_sthr[s_waddr] <= r_it.tid;
        end
        if (g_kwe) m_gkey[g_waddr] <= cur_key;
        if (g_ewe) m_gevt[g_waddr] <= g_ewdata;
        if (b_we)  m_bins[b_waddr] <= b_wdata;
    end

    always_comb begin
        n_st = r_st;  n_it = r_it;  n_scnt = r_scnt;  n_idx = r_idx;
        n_gcnt = r_gcnt;  n_gidx = r_gidx;  n_delta = r_delta;
        n_bin = r_bin;  n_clr = r_clr;  n_new = r_new;
        n_ov = 1'b0;  n_ost = ST_DONE;  n_ogv = 1'b0;  n_okey = '0;
        n_otot = '0;  n_obin = '0;
        o_q_pop = 1'b0;
        s_we = 1'b0;  s_wthr = 1'b0;  s_waddr = r_idx[SW-1:0];
        g_kwe = 1'b0;  g_ewe = 1'b0;  g_waddr = r_gidx[GW-1:0];
        g_ewdata = '0;
        b_we = 1'b0;  b_waddr = {r_gidx[GW-1:0], r_clr};  b_wdata = '0;

        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_it    = i_q_item;
                    n_idx   = '0;
                    n_gidx  = '0;
                    n_bin   = '0;
                    unique case (i_q_item.kind)
                        K_START, K_END: n_st = S_SRD;
                        K_READ: begin
                            if (32'(i_q_item.rgroup) < 32'(r_gcnt)) begin
                                n_st = S_RDW;
                            end else begin
                                n_ov = 1'b1;
                            end
                        end
                        default: begin
                            n_ov  = 1'b1;
                            n_ost = i_q_item.imm_status;
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (r_idx == r_scnt) begin
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                    if (r_it.kind == K_END) begin
                        n_ost = ST_NO_START;
                    end else if (32'(r_scnt) == 32'(START_ENTRIES)) begin
                        n_ost = ST_FULL;
                    end else begin
                        s_we   = 1'b1;
                        s_wthr = 1'b1;
                        n_scnt = r_scnt + SCW'(1);
                    end
                end else begin
                    n_st = S_SCMP;
                end
            end
            S_SCMP: begin
                if (rd_thr == r_it.tid) begin
                    if (r_it.kind == K_START) begin
                        s_we = 1'b1;
                        n_ov = 1'b1;
                        n_st = S_IDLE;
                    end else if (r_it.time_ns < rd_time) begin
                        n_ov  = 1'b1;
                        n_ost = ST_NO_START;
                        n_st  = S_IDLE;
                    end else begin
                        n_delta = r_it.time_ns - rd_time;
                        n_st    = S_GRD;
                    end
                end else begin
                    n_idx = r_idx + SCW'(1);
                    n_st  = S_SRD;
                end
            end
            S_GRD: begin
                if (r_gidx == r_gcnt) begin
                    if (32'(r_gcnt) == 32'(GROUP_ENTRIES)) begin
                        n_ov  = 1'b1;
                        n_ost = ST_FULL;
                        n_st  = S_IDLE;
                    end else begin
                        n_new = 1'b1;
                        n_st  = S_LOG;
                    end
                end else begin
                    n_st = S_GCMP;
                end
            end
            S_GCMP: begin
                if (rd_key == cur_key) begin
                    n_new = 1'b0;
                    n_st  = S_LOG;
                end else begin
                    n_gidx = r_gidx + GCW'(1);
                    n_st   = S_GRD;
                end
            end
            S_LOG: begin
                // floor(log2(delta / D)) >= k exactly when (delta >> k) >= D
                if (((r_delta >> 1) >= divisor) && (r_bin < BW'(NUM_BINS - 1))) begin
                    n_delta = r_delta >> 1;
                    n_bin   = r_bin + BW'(1);
                end else if (r_new) begin
                    g_kwe    = 1'b1;
                    g_ewe    = 1'b1;
                    g_ewdata = 32'd1;
                    n_gcnt   = r_gcnt + GCW'(1);
                    n_clr    = '0;
                    n_st     = S_CLR;
                end else begin
                    n_st = S_UPD;
                end
            end
            S_UPD: begin
                g_ewe    = 1'b1;
                g_ewdata = sat_inc(rd_evt);
                b_we     = 1'b1;
                b_waddr  = {r_gidx[GW-1:0], r_bin};
                b_wdata  = sat_inc(rd_bin);
                n_ov     = 1'b1;
                n_st     = S_IDLE;
            end
            S_CLR: begin
                b_we    = 1'b1;
                b_wdata = (r_clr == r_bin) ? 32'd1 : 32'd0;
                n_clr   = r_clr + BW'(1);
                if (r_clr == BW'(NUM_BINS - 1)) begin
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            S_RDW: begin
                n_ov   = 1'b1;
                n_ogv  = 1'b1;
                n_okey = rd_key;
                n_otot = rd_evt;
                n_obin = rb_ok ? rd_bin : 32'd0;
                n_st   = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_it    <= n_it;
        r_idx   <= n_idx;
        r_gidx  <= n_gidx;
        r_delta <= n_delta;
        r_bin   <= n_bin;
        r_clr   <= n_clr;
        r_new   <= n_new;
        r_ost   <= n_ost;
        r_ogv   <= n_ogv;
        r_okey  <= n_okey;
        r_otot  <= n_otot;
        r_obin  <= n_obin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_scnt <= '0;
            r_gcnt <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_scnt <= n_scnt;
            r_gcnt <= n_gcnt;
            r_ov   <= n_ov;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ost;
    assign o_group_valid  = r_ogv;
    assign o_group_key_id = r_okey.id;
    assign o_group_mode   = r_okey.mode;
    assign o_group_reason = r_okey.reason;
    assign o_group_total  = r_otot;
    assign o_bin_count    = r_obin;

endmodule

// File: test/kllh_result_checker.sv
`timescale 1ns / 100ps

module kllh_result_checker
    import kllh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_process_id,
    input  logic [31:0] i_thread_id,
    input  logic [63:0] i_time_ns,
    input  logic [2:0]  i_mode_code,
    input  logic [3:0]  i_reason_code,
    input  logic [5:0]  i_read_group,
    input  logic [4:0]  i_read_bin,
    input  logic        i_valid,
    input  logic [1:0]  i_status,
    input  logic        i_group_valid,
    input  logic [31:0] i_group_key_id,
    input  logic [2:0]  i_group_mode,
    input  logic [3:0]  i_group_reason,
    input  logic [31:0] i_group_total,
    input  logic [31:0] i_bin_count,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int N_START = 64;
    localparam int N_GROUP = 64;
    localparam int N_BIN   = 32;

    typedef struct packed {
        logic [1:0]  status;
        logic        gvalid;
        logic [31:0] key_id;
        logic [2:0]  mode;
        logic [3:0]  reason;
        logic [31:0] total;
        logic [31:0] bin;
    } t_hist_out;

    t_cfg        cfg_q;
    logic        thr_used [N_START];
    logic [31:0] thr_id   [N_START];
    logic [63:0] thr_time [N_START];
    logic        grp_used [N_GROUP];
    t_gkey       grp_key  [N_GROUP];
    logic [31:0] grp_total[N_GROUP];
    logic [31:0] grp_bins [N_GROUP][N_BIN];

    t_hist_out   hist_expected[$];
    int          mismatches;

    assign o_pending    = hist_expected.size();
    assign o_fail_count = mismatches;

    function automatic logic [31:0] bump(input logic [31:0] c);
        bump = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // Applies one command to the shadow tables and returns what the block should say.
    function automatic t_hist_out hist_predict(input logic [1:0] op, input logic [31:0] pid,
            input logic [31:0] tid, input logic [63:0] t, input logic [2:0] mode,
            input logic [3:0] reason, input logic [5:0] rg, input logic [4:0] rb);
        t_hist_out   r;
        int          s, g, fs;
        t_gkey       key;
        logic [63:0] d;
        int          b;
        r = '0;
        if (op == OP_START || op == OP_END) begin
            if (cfg_q.filter_en && pid != cfg_q.filter_pid) begin
                r.status = ST_FILTERED;
                return r;
            end
            s = -1;
            fs = -1;
            for (int i = 0; i < N_START; i++) begin
                if (s < 0 && thr_used[i] && thr_id[i] == tid) s = i;
                if (!thr_used[i] && fs < 0) fs = i;
            end
            if (op == OP_START) begin
                if (s >= 0) begin
                    thr_time[s] = t;
                end else if (fs < 0) begin
                    r.status = ST_FULL;
                end else begin
                    thr_used[fs] = 1'b1;
                    thr_id[fs]   = tid;
                    thr_time[fs] = t;
                end
                return r;
            end
            if (s < 0 || t < thr_time[s]) begin
                r.status = ST_NO_START;
                return r;
            end
            case (cfg_q.group_by)
                GB_PROCESS: key.id = pid;
                GB_THREAD:  key.id = tid;
                default:    key.id = GLOBAL_ID;
            endcase
            key.mode   = mode;
            key.reason = reason;
            g = -1;
            fs = -1;
            for (int i = 0; i < N_GROUP; i++) begin
                if (grp_used[i]) begin
                    if (g < 0 && grp_key[i] == key) g = i;
                end else if (fs < 0) begin
                    fs = i;
                end
            end
            if (g < 0) begin
                if (fs < 0) begin
                    r.status = ST_FULL;
                    return r;
                end
                g = fs;
                grp_used[g]  = 1'b1;
                grp_key[g]   = key;
                grp_total[g] = '0;
                for (int j = 0; j < N_BIN; j++) grp_bins[g][j] = '0;
            end
            d = (t - thr_time[s]) / (cfg_q.unit_ms ? 64'd1000000 : 64'd1000);
            b = 0;
            while (d > 64'd1) begin
                d = d >> 1;
                b++;
            end
            if (b >= N_BIN) b = N_BIN - 1;
            grp_total[g]   = bump(grp_total[g]);
            grp_bins[g][b] = bump(grp_bins[g][b]);
        end else if (op == OP_READ && grp_used[rg]) begin
            r.gvalid = 1'b1;
            r.key_id = grp_key[rg].id;
            r.mode   = grp_key[rg].mode;
            r.reason = grp_key[rg].reason;
            r.total  = grp_total[rg];
            r.bin    = grp_bins[rg][rb];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hist_out got, want;
        if (!i_rst_n) begin
            cfg_q <= '0;
            for (int i = 0; i < N_START; i++) thr_used[i] = 1'b0;
            for (int i = 0; i < N_GROUP; i++) grp_used[i] = 1'b0;
            hist_expected.delete();
            mismatches <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FILTER_EN:  cfg_q.filter_en  <= i_cfg_data[0];
                    CFG_FILTER_PID: cfg_q.filter_pid <= i_cfg_data;
                    CFG_GROUP_BY:   cfg_q.group_by   <= i_cfg_data[1:0];
                    CFG_UNIT_MS:    cfg_q.unit_ms    <= i_cfg_data[0];
                endcase
            end
            if (i_valid) begin
                got = {i_status, i_group_valid, i_group_key_id, i_group_mode,
                       i_group_reason, i_group_total, i_bin_count};
                if (hist_expected.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing pending: %h", $time, got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = hist_expected.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch st %0d/%0d gv %0d/%0d id %h/%h md %0d/%0d rs %0d/%0d tot %0d/%0d bin %0d/%0d",
                                $time, want.status, got.status, want.gvalid, got.gvalid,
                                want.key_id, got.key_id, want.mode, got.mode,
                                want.reason, got.reason, want.total, got.total,
                                want.bin, got.bin);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                hist_expected.push_back(hist_predict(i_op, i_process_id, i_thread_id,
                    i_time_ns, i_mode_code, i_reason_code, i_read_group, i_read_bin));
        end
    end

endmodule

// File: test/tb_keyed_latency_log2_histogram_core.sv
`timescale 1ns / 100ps

module tb_keyed_latency_log2_histogram_core;
    import kllh_pkg::*;

    // Worst-case back-end time of one transaction: two table scans of 64 entries,
    // the log2 shift and the bin-row init, with generous margin.
    localparam int DRAIN_CYCLES = 600;
    localparam int STALL_LIMIT  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = '0;
    logic [31:0] i_process_id = '0;
    logic [31:0] i_thread_id = '0;
    logic [63:0] i_time_ns = '0;
    logic [2:0]  i_mode_code = '0;
    logic [3:0]  i_reason_code = '0;
    logic [5:0]  i_read_group = '0;
    logic [4:0]  i_read_bin = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_group_valid;
    logic [31:0] o_group_key_id;
    logic [2:0]  o_group_mode;
    logic [3:0]  o_group_reason;
    logic [31:0] o_group_total;
    logic [31:0] o_bin_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int stall_cycles;
    int n_cmds;
    int n_results;
    bit gaps_on = 1'b1;

    // Start times handed out per thread, so end events can be made to match.
    logic [63:0] issued_start[logic [31:0]];

    always #5 i_clk = ~i_clk;

    keyed_latency_log2_histogram_core u_top (.*);

    kllh_result_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_op, .i_process_id,
        .i_thread_id, .i_time_ns, .i_mode_code, .i_reason_code, .i_read_group,
        .i_read_bin, .i_valid(o_valid), .i_status(o_status),
        .i_group_valid(o_group_valid), .i_group_key_id(o_group_key_id),
        .i_group_mode(o_group_mode), .i_group_reason(o_group_reason),
        .i_group_total(o_group_total), .i_bin_count(o_bin_count), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: any accepted transaction or result counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
        if (i_rst_n && o_valid) n_results <= n_results + 1;
    end

    // Present one command and hold it until the block takes it. start stays high
    // afterwards; the next gap, a register write or the end of the run lowers it.
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] pid,
            input logic [31:0] tid, input logic [63:0] t, input logic [2:0] mode,
            input logic [3:0] reason, input logic [5:0] rg, input logic [4:0] rb);
        bit taken;
        int gap;
        if (gaps_on && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_process_id  <= pid;
        i_thread_id   <= tid;
        i_time_ns     <= t;
        i_mode_code   <= mode;
        i_reason_code <= reason;
        i_read_group  <= rg;
        i_read_bin    <= rb;
        if (op == OP_START) issued_start[tid] = t;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        n_cmds++;
    endtask

    // Register writes happen only with the block idle: the sender stops, every
    // expected result drains, then the back end is given time to settle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        bit taken;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic fen, input logic [31:0] fpid,
            input logic [1:0] gb, input logic ms);
        write_reg(CFG_FILTER_EN, {31'd0, fen});
        write_reg(CFG_FILTER_PID, fpid);
        write_reg(CFG_GROUP_BY, {30'd0, gb});
        write_reg(CFG_UNIT_MS, {31'd0, ms});
    endtask

    function automatic logic [31:0] pick_pid();
        case ($urandom_range(0, 5))
            0:       pick_pid = 32'd0;
            1:       pick_pid = 32'hFFFF_FFFF;
            2:       pick_pid = $urandom;
            default: pick_pid = $urandom_range(1, 4);
        endcase
    endfunction

    // Threads come mostly from a pool a bit wider than the start table, so the
    // table fills over a phase and later starts hit the full case.
    function automatic logic [31:0] pick_tid();
        case ($urandom_range(0, 19))
            0:       pick_tid = $urandom;
            1:       pick_tid = 32'hFFFF_FFFF;
            default: pick_tid = $urandom_range(0, 79);
        endcase
    endfunction

    // Latency that spreads over all bins, including well past the last one.
    function automatic logic [63:0] pick_delta();
        int sh;
        sh = $urandom_range(0, 63);
        pick_delta = {$urandom, $urandom} >> (63 - sh);
    endfunction

    task automatic random_cmds(input int count);
        logic [31:0] tid;
        logic [63:0] t;
        int          k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            tid = pick_tid();
            if (k < 38) begin
                t = $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                                              : {8'd0, $urandom, 24'($urandom)};
                send_cmd(OP_START, pick_pid(), tid, t, 3'($urandom), 4'($urandom),
                         6'($urandom), 5'($urandom));
            end else if (k < 85) begin
                if (issued_start.exists(tid) && $urandom_range(0, 9) != 0) begin
                    if ($urandom_range(0, 9) == 0)
                        t = issued_start[tid] - 64'($urandom_range(1, 1000));
                    else
                        t = issued_start[tid] + pick_delta();
                end else begin
                    t = {$urandom, $urandom};
                end
                // Few mode/reason values so groups recur and counts build up.
                send_cmd(OP_END, pick_pid(), tid, t, 3'($urandom_range(0, 2)),
                         4'($urandom_range(0, 2)), 6'($urandom), 5'($urandom));
            end else if (k < 97) begin
                send_cmd(OP_READ, $urandom, $urandom, {$urandom, $urandom}, 3'($urandom),
                         4'($urandom), 6'($urandom_range(0, 12)), 5'($urandom));
            end else begin
                send_cmd(2'd3, $urandom, $urandom, {$urandom, $urandom}, 3'($urandom),
                         4'($urandom), 6'($urandom), 5'($urandom));
            end
        end
    endtask

    initial begin
        stall_cycles = 0;
        n_cmds = 0;
        n_results = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults (no filter, global key, microseconds).
        send_cmd(OP_READ, '0, '0, '0, '0, '0, 6'd0, 5'd0);               // unused group
        send_cmd(OP_END, 32'd7, 32'd100, 64'd5000, 3'd1, 4'd1, '0, '0);  // no start
        send_cmd(OP_START, 32'd7, 32'd100, 64'd1000, '0, '0, '0, '0);
        send_cmd(OP_END, 32'd7, 32'd100, 64'd999, 3'd1, 4'd1, '0, '0);   // clock backwards
        send_cmd(OP_END, 32'd7, 32'd100, 64'd1000, 3'd0, 4'd0, '0, '0);  // zero delta
        send_cmd(OP_START, 32'd7, 32'd100, 64'd2000, '0, '0, '0, '0);    // overwrite
        send_cmd(OP_END, 32'd7, 32'd100, 64'd10000, 3'd7, 4'd15, '0, '0);
        send_cmd(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 3'd7, 4'd15, '1, '1);
        send_cmd(OP_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 4'd15,
                 '0, '0);                                                 // clamp to last bin
        send_cmd(2'd3, '1, '1, '1, '1, '1, '1, '1);                       // unused op
        send_cmd(OP_READ, '0, '0, '0, '0, '0, 6'd0, 5'd0);
        send_cmd(OP_READ, '0, '0, '0, '0, '0, 6'd1, 5'd3);
        send_cmd(OP_READ, '0, '0, '0, '0, '0, 6'd2, 5'd31);
        send_cmd(OP_READ, '0, '0, '0, '0, '0, 6'd63, 5'd31);

        // Filter on an extreme pid, per-process key, milliseconds.
        set_config(1'b1, 32'hFFFF_FFFF, GB_PROCESS, 1'b1);
        send_cmd(OP_START, 32'd5, 32'd200, 64'd0, '0, '0, '0, '0);        // filtered
        send_cmd(OP_START, 32'hFFFF_FFFF, 32'd200, 64'd0, '0, '0, '0, '0);
        send_cmd(OP_END, 32'd5, 32'd200, 64'd5000000, '0, '0, '0, '0);    // filtered
        send_cmd(OP_END, 32'hFFFF_FFFF, 32'd200, 64'd5000000, 3'd2, 4'd3, '0, '0);
        send_cmd(OP_READ, '0, '0, '0, '0, '0, 6'd3, 5'd2);
        // Unused group_by code falls back to the global key.
        set_config(1'b0, 32'd0, 2'd3, 1'b0);
        send_cmd(OP_END, 32'd1, 32'd200, 64'd9000000, 3'd2, 4'd3, '0, '0);
        send_cmd(OP_READ, '0, '0, '0, '0, '0, 6'd4, 5'd13);

        // Random phases over several register settings.
        set_config(1'b0, 32'd0, GB_THREAD, 1'b0);
        random_cmds(100);
        set_config(1'b1, 32'd2, GB_PROCESS, 1'b1);
        gaps_on = 1'b0;                                                   // back-to-back stretch
        random_cmds(100);
        gaps_on = 1'b1;
        set_config(1'b0, 32'hFFFF_FFFF, 2'd0, 1'b0);
        random_cmds(100);
        set_config(1'b1, 32'd0, GB_THREAD, 1'b1);
        random_cmds(100);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands and %0d results over 7 register settings,", n_cmds,
                 n_results);
        $display("with filtering, all key modes, both units and full start/group tables");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
